/* hw/rtl/luinv_pkg.sv */
// Shared widths, constants and saturation helper for the LU matrix inverse.
// Used by the divider and the top level; depends on nothing.
`default_nettype none

package luinv_pkg;

  localparam int DATA_W = 32;
  localparam int DET_W = 48;
  localparam int IDX_W = 3;
  localparam int ACC_W = 52;
  localparam int NUM_W = 53;
  localparam int DEF_MAX_ORDER = 8;

  localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [DET_W-1:0] ONE_Q24 = 48'sh0000_0100_0000;
  localparam logic signed [DET_W-1:0] DET_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [DET_W-1:0] DET_MIN = 48'sh8000_0000_0000;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [NUM_W-1:0] v);
    logic signed [NUM_W-1:0] hi;
    logic signed [NUM_W-1:0] lo;
    hi = NUM_W'(32'sh7FFF_FFFF);
    lo = -NUM_W'(33'sh1_0000_0000) + NUM_W'(32'sh8000_0000);
    lo = {{(NUM_W-DATA_W){1'b1}}, 32'h8000_0000};
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/luinv_div.sv */
// Restoring Q16.16 divider, one quotient bit per cycle, saturating result.
// Depends on luinv_pkg.
`default_nettype none

module luinv_div import luinv_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [NUM_W-1:0]  num,
  input  wire logic signed [DATA_W-1:0] den,
  output logic                          done,
  output logic signed [DATA_W-1:0]      quo
);

  localparam int NW = NUM_W + 16;
  localparam int TW = NW - 33;

  logic              busy;
  logic [5:0]        cnt;
  logic [31:0]       rem;
  logic [32:0]       sh;
  logic [31:0]       ud;
  logic              neg;

  logic [NUM_W-1:0]  un;
  logic [NW-1:0]     nn;
  logic [TW-1:0]     top;
  logic [31:0]       uden;
  logic [32:0]       t;
  logic              ge;
  logic [31:0]       rem_next;

  function automatic logic signed [31:0] satq(input logic n, input logic ovf,
                                              input logic [32:0] q);
    if (n) begin
      if (ovf || q >= 33'h0_8000_0000) begin
        satq = 32'sh8000_0000;
      end else begin
        satq = -$signed(q[31:0]);
      end
    end else if (ovf || q[32] || q[31]) begin
      satq = 32'sh7FFF_FFFF;
    end else begin
      satq = $signed(q[31:0]);
    end
  endfunction

  always_comb begin
    un = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    nn = {un, 16'b0};
    top = nn[NW-1:33];
    uden = den[DATA_W-1] ? 32'(-den) : 32'(den);
    t = {rem, sh[32]};
    ge = t >= {1'b0, ud};
    rem_next = ge ? 32'(t - {1'b0, ud}) : t[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= num[NUM_W-1] ^ den[DATA_W-1];
        ud <= uden;
        if (top >= TW'(uden)) begin
          quo <= satq(num[NUM_W-1] ^ den[DATA_W-1], 1'b1, 33'b0);
          done <= 1'b1;
        end else begin
          rem <= top[31:0];
          sh <= nn[32:0];
          cnt <= 6'd33;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= rem_next;
        sh <= {sh[31:0], ge};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
          quo <= satq(neg, 1'b0, {sh[31:0], ge});
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lu_matrix_inverse.sv */
// LU matrix inverse: loads n*n Q16.16 beats at one per cycle, then factors, solves, emits n*n.
// After the last load beat, one shared 33x33 multiplier and a bit-serial divider do the
// factoring, determinant and solves; then each result beat passes through E_RD, E_RDW and
// E_WAIT, where it waits for m_axis_tready. A zero pivot ends the run with one beat.
// No input is taken until the last result beat is accepted. Synchronous reset sets the order
// to MAX_ORDER and clears the load position and determinant; the memories are not cleared.
`default_nettype none

module lu_matrix_inverse import luinv_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,      // matrix_size
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // elem_value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,  // inv_value, row_index, col_index, det_value
  output logic [0:0]       m_axis_tuser,  // singular
  output logic             m_axis_tlast
);

  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(MAX_ORDER);

  localparam logic [4:0] ST_LOAD = 5'd0;
  localparam logic [4:0] F_PIV   = 5'd1;
  localparam logic [4:0] F_PIVW  = 5'd2;
  localparam logic [4:0] F_LD    = 5'd3;
  localparam logic [4:0] F_LDW   = 5'd4;
  localparam logic [4:0] F_DIV   = 5'd5;
  localparam logic [4:0] F_RKJ   = 5'd6;
  localparam logic [4:0] F_RKJW  = 5'd7;
  localparam logic [4:0] F_UPD   = 5'd8;
  localparam logic [4:0] D_RD    = 5'd9;
  localparam logic [4:0] D_RDW   = 5'd10;
  localparam logic [4:0] D_M0    = 5'd11;
  localparam logic [4:0] D_M1    = 5'd12;
  localparam logic [4:0] D_M2    = 5'd13;
  localparam logic [4:0] S_FI    = 5'd14;
  localparam logic [4:0] S_FRD   = 5'd15;
  localparam logic [4:0] S_FRW   = 5'd16;
  localparam logic [4:0] S_FAC   = 5'd17;
  localparam logic [4:0] S_FWR   = 5'd18;
  localparam logic [4:0] S_BI    = 5'd19;
  localparam logic [4:0] S_BRD   = 5'd20;
  localparam logic [4:0] S_BRW   = 5'd21;
  localparam logic [4:0] S_BAC   = 5'd22;
  localparam logic [4:0] S_BD    = 5'd23;
  localparam logic [4:0] S_BDW   = 5'd24;
  localparam logic [4:0] S_BDIV  = 5'd25;
  localparam logic [4:0] E_RD    = 5'd26;
  localparam logic [4:0] E_RDW   = 5'd27;
  localparam logic [4:0] E_WAIT  = 5'd28;

  function automatic logic [AW-1:0] maddr(input logic [IDX_W-1:0] r,
                                          input logic [IDX_W-1:0] c);
    maddr = AW'(32'(r) * MAX_ORDER + 32'(c));
  endfunction

  logic [4:0]               state;
  logic [IDX_W-1:0]         nm1, lrow, lcol, k, i, j;
  logic signed [DATA_W-1:0] mat [DEPTH];
  logic signed [DATA_W-1:0] inv [DEPTH];
  logic signed [DATA_W-1:0] rdata, inv_rdata;
  logic signed [DATA_W-1:0] yv [MAX_ORDER];
  logic signed [DATA_W-1:0] xv [MAX_ORDER];
  logic signed [DATA_W-1:0] piv, f;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DET_W-1:0]  det;
  logic [31:0]              pmag;
  logic                     psign;
  logic [55:0]              p0;
  logic signed [65:0]       prod;
  logic signed [DATA_W-1:0] out_inv;
  logic [IDX_W-1:0]         out_row, out_col;
  logic                     out_sing, out_last;

  logic [AW-1:0]            raddr, waddr;
  logic                     we;
  logic signed [DATA_W-1:0] wdata;
  logic signed [32:0]       ma, mb;
  logic signed [49:0]       mq;
  logic [47:0]              dmag;
  logic [79:0]              dfull;
  logic [63:0]              dnew;
  logic signed [DET_W-1:0]  det_res;
  logic                     div_start, div_done;
  logic signed [NUM_W-1:0]  div_num;
  logic signed [DATA_W-1:0] div_quo;
  logic signed [DATA_W-1:0] e_val;
  logic                     s_acc;

  luinv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_start && state == S_BDW ? rdata : (state == F_LDW ? piv : rdata)),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == ST_LOAD);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state == E_WAIT);
  assign m_axis_tdata = {2'b0, det, out_col, out_row, out_inv};
  assign m_axis_tuser = out_sing;
  assign m_axis_tlast = out_last;

  always_comb begin
    mq = 50'(prod >>> 16) + 50'(prod[65] && (prod[15:0] != 16'b0));
    dmag = det[DET_W-1] ? 48'(-det) : 48'(det);
    dfull = {prod[55:0], 24'b0} + {24'b0, p0};
    dnew = dfull[79:16];
    if (psign ^ det[DET_W-1]) begin
      det_res = (dnew >= 64'h8000_0000_0000) ? DET_MIN : -$signed(DET_W'(dnew));
    end else begin
      det_res = (dnew > 64'h7FFF_FFFF_FFFF) ? DET_MAX : $signed(DET_W'(dnew));
    end
    e_val = (i == k) ? ONE_Q16 : '0;
  end

  always_comb begin
    raddr = '0;
    ma = '0;
    mb = '0;
    div_start = 1'b0;
    div_num = NUM_W'(rdata);
    unique case (state)
      F_PIV:  raddr = maddr(k, k);
      F_LD:   raddr = maddr(i, k);
      F_LDW:  div_start = 1'b1;
      F_RKJ:  raddr = maddr(k, j);
      F_RKJW: begin
        raddr = maddr(i, j);
        ma = 33'(f);
        mb = 33'(rdata);
      end
      D_RD:   raddr = maddr(i, i);
      D_M0: begin
        ma = $signed({9'b0, dmag[23:0]});
        mb = $signed({1'b0, pmag});
      end
      D_M1: begin
        ma = $signed({9'b0, dmag[47:24]});
        mb = $signed({1'b0, pmag});
      end
      S_FRD:  raddr = maddr(i, j);
      S_FRW: begin
        ma = 33'(rdata);
        mb = 33'(yv[j[IW-1:0]]);
      end
      S_BRD:  raddr = maddr(i, j);
      S_BRW: begin
        ma = 33'(rdata);
        mb = 33'(xv[j[IW-1:0]]);
      end
      S_BD:   raddr = maddr(i, i);
      S_BDW: begin
        div_start = 1'b1;
        div_num = NUM_W'(yv[i[IW-1:0]]) - NUM_W'(acc);
      end
      default: raddr = '0;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = maddr(lrow, lcol);
    wdata = $signed(s_axis_tdata);
    if (state == ST_LOAD) begin
      we = s_acc;
    end else if (state == F_DIV) begin
      we = div_done;
      waddr = maddr(i, k);
      wdata = div_quo;
    end else if (state == F_UPD) begin
      we = 1'b1;
      waddr = maddr(i, j);
      wdata = sat32(NUM_W'(rdata) - NUM_W'(mq));
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mat[waddr] <= wdata;
    end
    rdata <= mat[raddr];
    if (state == S_BDIV && div_done) begin
      inv[maddr(i, k)] <= div_quo;
    end
    inv_rdata <= inv[maddr(i, j)];
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      nm1 <= IDX_W'(MAX_ORDER - 1);
      lrow <= '0;
      lcol <= '0;
      det <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (s_acc) begin
            if (lcol == nm1) begin
              lcol <= '0;
              if (lrow == nm1) begin
                lrow <= '0;
                k <= '0;
                state <= F_PIV;
              end else begin
                lrow <= lrow + 1'b1;
              end
            end else begin
              lcol <= lcol + 1'b1;
            end
          end
        end
        F_PIV:  state <= F_PIVW;
        F_PIVW: begin
          piv <= rdata;
          if (rdata == '0) begin
            det <= '0;
            out_inv <= '0;
            out_row <= '0;
            out_col <= '0;
            out_sing <= 1'b1;
            out_last <= 1'b1;
            state <= E_WAIT;
          end else if (k == nm1) begin
            det <= ONE_Q24;
            i <= '0;
            state <= D_RD;
          end else begin
            i <= k + 1'b1;
            state <= F_LD;
          end
        end
        F_LD:   state <= F_LDW;
        F_LDW:  state <= F_DIV;
        F_DIV: begin
          if (div_done) begin
            f <= div_quo;
            j <= k + 1'b1;
            state <= F_RKJ;
          end
        end
        F_RKJ:  state <= F_RKJW;
        F_RKJW: state <= F_UPD;
        F_UPD: begin
          if (j == nm1) begin
            if (i == nm1) begin
              k <= k + 1'b1;
              state <= F_PIV;
            end else begin
              i <= i + 1'b1;
              state <= F_LD;
            end
          end else begin
            j <= j + 1'b1;
            state <= F_RKJ;
          end
        end
        D_RD:   state <= D_RDW;
        D_RDW: begin
          pmag <= rdata[DATA_W-1] ? 32'(-rdata) : 32'(rdata);
          psign <= rdata[DATA_W-1];
          state <= D_M0;
        end
        D_M0:   state <= D_M1;
        D_M1: begin
          p0 <= prod[55:0];
          state <= D_M2;
        end
        D_M2: begin
          det <= det_res;
          if (i == nm1) begin
            k <= '0;
            i <= '0;
            state <= S_FI;
          end else begin
            i <= i + 1'b1;
            state <= D_RD;
          end
        end
        S_FI: begin
          acc <= '0;
          j <= '0;
          state <= (i == '0) ? S_FWR : S_FRD;
        end
        S_FRD:  state <= S_FRW;
        S_FRW:  state <= S_FAC;
        S_FAC: begin
          acc <= acc + ACC_W'(mq);
          if (j == i - 1'b1) begin
            state <= S_FWR;
          end else begin
            j <= j + 1'b1;
            state <= S_FRD;
          end
        end
        S_FWR: begin
          yv[i[IW-1:0]] <= sat32(NUM_W'(e_val) - NUM_W'(acc));
          if (i == nm1) begin
            state <= S_BI;
          end else begin
            i <= i + 1'b1;
            state <= S_FI;
          end
        end
        S_BI: begin
          acc <= '0;
          j <= i + 1'b1;
          state <= (i == nm1) ? S_BD : S_BRD;
        end
        S_BRD:  state <= S_BRW;
        S_BRW:  state <= S_BAC;
        S_BAC: begin
          acc <= acc + ACC_W'(mq);
          if (j == nm1) begin
            state <= S_BD;
          end else begin
            j <= j + 1'b1;
            state <= S_BRD;
          end
        end
        S_BD:   state <= S_BDW;
        S_BDW:  state <= S_BDIV;
        S_BDIV: begin
          if (div_done) begin
            xv[i[IW-1:0]] <= div_quo;
            if (i == '0) begin
              if (k == nm1) begin
                j <= '0;
                state <= E_RD;
              end else begin
                k <= k + 1'b1;
                state <= S_FI;
              end
            end else begin
              i <= i - 1'b1;
              state <= S_BI;
            end
          end
        end
        E_RD:   state <= E_RDW;
        E_RDW: begin
          out_inv <= inv_rdata;
          out_row <= i;
          out_col <= j;
          out_sing <= 1'b0;
          out_last <= (i == nm1) && (j == nm1);
          state <= E_WAIT;
        end
        E_WAIT: begin
          if (m_axis_tready) begin
            if (out_last) begin
              state <= ST_LOAD;
            end else begin
              if (j == nm1) begin
                j <= '0;
                i <= i + 1'b1;
              end else begin
                j <= j + 1'b1;
              end
              state <= E_RD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
      if (cfg_valid && cfg_ready) begin
        lrow <= '0;
        lcol <= '0;
        if (cfg_data == 4'd0) begin
          nm1 <= '0;
        end else if (cfg_data > 4'(MAX_ORDER)) begin
          nm1 <= IDX_W'(MAX_ORDER - 1);
        end else begin
          nm1 <= IDX_W'(cfg_data - 4'd1);
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result beat is pending");

  a_sing_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("singular beat is not the last of its run");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("block did not return to loading after the last beat");
`endif

endmodule

`default_nettype wire

/* dv/tb_lu_matrix_inverse.sv */
// Testbench for lu_matrix_inverse: loads matrices over the input stream and checks every
// inverse beat against a fixed-point predictor kept in this file.
// Depends on luinv_pkg and lu_matrix_inverse only.
`timescale 1ns / 1ps

module tb_lu_matrix_inverse;
  import luinv_pkg::*;

  localparam int ORDER_MAX = 8;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct {
    logic signed [31:0] inv;
    logic [2:0] row;
    logic [2:0] col;
    logic signed [47:0] det;
    logic singular;
    logic last;
  } inv_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic m_axis_tlast;

  inv_beat_t expected_beats[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;

  int order = ORDER_MAX;
  int load_pos = 0;
  int mat[ORDER_MAX][ORDER_MAX];
  int lfac[ORDER_MAX][ORDER_MAX];
  int fwd[ORDER_MAX];
  int sol[ORDER_MAX];
  int inv_mat[ORDER_MAX][ORDER_MAX];

  lu_matrix_inverse dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return int'(v);
  endfunction

  function automatic longint qmul(int a, int b);
    return (longint'(a) * longint'(b)) / 65536;
  endfunction

  function automatic int qdiv(longint num, int den);
    longint unsigned un, ud, q, r, mag;
    logic neg;
    un = (num < 0) ? longint'(-num) : num;
    ud = (den < 0) ? -longint'(den) : longint'(den);
    q = un / ud;
    r = un % ud;
    neg = (num < 0) != (den < 0);
    if (q >= 65536) mag = 64'h1_0000_0000;
    else mag = q * 65536 + (r * 65536) / ud;
    if (neg) begin
      if (mag >= 64'h8000_0000) return 32'h8000_0000;
      return int'(-longint'(mag));
    end
    if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return int'(mag);
  endfunction

  function automatic longint det_scale(longint d, int p);
    longint unsigned ud, up, mag;
    logic neg;
    ud = (d < 0) ? longint'(-d) : d;
    up = (p < 0) ? -longint'(p) : longint'(p);
    mag = ud * (up >> 16) + (ud * (up & 64'hFFFF)) / 65536;
    neg = (d < 0) != (p < 0);
    if (neg) begin
      if (mag >= 64'h8000_0000_0000) return -64'sd140737488355328;
      return -longint'(mag);
    end
    if (mag > 64'h7FFF_FFFF_FFFF) return 64'sd140737488355327;
    return longint'(mag);
  endfunction

  function automatic logic factor_lu(int n);
    int f;
    for (int k = 0; k < n; k++) begin
      if (mat[k][k] == 0) return 1'b0;
      for (int i = k + 1; i < n; i++) begin
        f = qdiv(longint'(mat[i][k]), mat[k][k]);
        lfac[i][k] = f;
        for (int j = k + 1; j < n; j++) begin
          mat[i][j] = clip32(longint'(mat[i][j]) - qmul(f, mat[k][j]));
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic void solve_unit_column(int n, int k);
    longint s;
    for (int i = 0; i < n; i++) begin
      s = 0;
      for (int j = 0; j < i; j++) s += qmul(lfac[i][j], fwd[j]);
      fwd[i] = clip32(((i == k) ? 64'sd65536 : 64'sd0) - s);
    end
    for (int i = n - 1; i >= 0; i--) begin
      s = 0;
      for (int j = i + 1; j < n; j++) s += qmul(mat[i][j], sol[j]);
      sol[i] = qdiv(longint'(fwd[i]) - s, mat[i][i]);
    end
    for (int i = 0; i < n; i++) inv_mat[i][k] = sol[i];
  endfunction

  function automatic void predict_inverse(int x);
    inv_beat_t b;
    longint d;
    if (load_pos >= order * order) load_pos = 0;
    mat[load_pos / order][load_pos % order] = x;
    load_pos++;
    if (load_pos < order * order) return;
    load_pos = 0;
    if (!factor_lu(order)) begin
      b = '{inv: '0, row: '0, col: '0, det: '0, singular: 1'b1, last: 1'b1};
      expected_beats.push_back(b);
      return;
    end
    d = 64'sd16777216;
    for (int i = 0; i < order; i++) d = det_scale(d, mat[i][i]);
    for (int k = 0; k < order; k++) solve_unit_column(order, k);
    for (int i = 0; i < order; i++) begin
      for (int j = 0; j < order; j++) begin
        b.inv = inv_mat[i][j];
        b.row = i[2:0];
        b.col = j[2:0];
        b.det = d[47:0];
        b.singular = 1'b0;
        b.last = (i == order - 1) && (j == order - 1);
        expected_beats.push_back(b);
      end
    end
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_lu_matrix_inverse: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    inv_beat_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t unexpected beat: actual %h user %b last %b", $time,
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        e = expected_beats.pop_front();
        if (m_axis_tdata[31:0] !== e.inv || m_axis_tdata[34:32] !== e.row ||
            m_axis_tdata[37:35] !== e.col || m_axis_tdata[85:38] !== e.det ||
            m_axis_tuser[0] !== e.singular || m_axis_tlast !== e.last) begin
          errors++;
          $display("%0t mismatch: expected inv %h row %0d col %0d det %h sing %b last %b",
                   $time, e.inv, e.row, e.col, e.det, e.singular, e.last);
          $display("%0t           actual   inv %h row %0d col %0d det %h sing %b last %b",
                   $time, m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tdata[37:35],
                   m_axis_tdata[85:38], m_axis_tuser[0], m_axis_tlast);
        end
      end
    end
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_elem(input int x);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= x;
    do @(posedge clk); while (!s_axis_tready);
    predict_inverse(x);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(input logic [3:0] v);
    wait_drain();
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    order = (v == 0) ? 1 : ((v > ORDER_MAX) ? ORDER_MAX : v);
    load_pos = 0;
  endtask

  // Mostly diagonally dominant matrices, some raw 32-bit noise, some with a zero top-left pivot.
  task automatic send_matrix(input int n);
    int kind;
    int x;
    kind = $urandom_range(99);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (kind < 15) begin
          x = $urandom;
        end else begin
          x = $urandom_range(32'h3FFFF) - 32'h20000;
          if (i == j) x += (($urandom_range(1) != 0) ? 1 : -1) * (n * 4 + 1) * 65536;
          if (kind >= 88 && i == 0 && j == 0) x = 0;
        end
        send_elem(x);
      end
    end
  endtask

  task automatic test_directed();
    write_size(4'd1);
    send_elem(32'h7FFF_FFFF);
    send_elem(32'h8000_0000);
    send_elem(32'h0000_0000);
    send_elem(32'h0000_0001);
    send_elem(32'hFFFF_FFFF);
    write_size(4'd0);
    send_elem(32'h0002_0000);
    write_size(4'd2);
    send_elem(32'h0001_0000);
    send_elem(32'h0000_0000);
    send_elem(32'h0000_0000);
    send_elem(32'h0001_0000);
    send_elem(32'h0000_0000);
    send_elem(32'h0001_0000);
    send_elem(32'h0001_0000);
    send_elem(32'h0001_0000);
    send_elem(32'h0000_0100);
    send_elem(32'h0000_0000);
    send_elem(32'h0000_0000);
    send_elem(32'h0000_0100);
    write_size(4'd15);
    send_elem(32'h0003_0000);
    send_elem(32'h0001_0000);
    send_elem(32'h1234_5678);
    write_size(4'd2);
    send_elem(32'h0000_0000);
    send_elem(32'h0001_0000);
    send_elem(32'h0001_0000);
    send_elem(32'h0000_0000);
  endtask

  task automatic test_random_run(input int items, input int s_pct, input int r_pct);
    int sent;
    int n;
    int pick;
    sent = 0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (sent < items) begin
      pick = $urandom_range(99);
      n = (pick < 5) ? 8 : ((pick < 15) ? 1 : $urandom_range(4, 2));
      write_size(n[3:0]);
      repeat ($urandom_range(3, 1)) begin
        send_matrix(n);
        sent += n * n;
      end
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_size(4'd3);
    recv_hold = 4000;
    send_matrix(3);
    send_matrix(3);
    send_matrix(3);
    wait_drain();
    send_matrix(3);
  endtask

  task automatic test_full_order();
    write_size(4'd8);
    send_matrix(8);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_output_backpressure();
    test_random_run(30, 13, 45);
    test_random_run(30, 45, 13);
    test_random_run(30, 0, 0);
    test_full_order();
    wait_drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("tb_lu_matrix_inverse: PASS");
    end else begin
      $display("tb_lu_matrix_inverse: FAIL");
    end
    $finish;
  end

endmodule
